// ----- design/mpp_pkg.sv -----
// ----------------------------------------------------------------------------
// MQTT PUBLISH parser package
// Parser phases, byte classes, status codes, register indexes and the
// layout of one result item.
// ----------------------------------------------------------------------------
package mpp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_PID,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FRAME,
        KIND_TOPIC,
        KIND_PAYLOAD
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_HEADER,
        ST_LEN_TOO_LONG,
        ST_TOPIC_TOO_LONG,
        ST_PAYLOAD_TOO_LONG
    } status_t;

    typedef enum logic [0:0] {
        CFG_TOPIC_LIMIT,
        CFG_PAYLOAD_LIMIT
    } cfg_index_t;

    localparam int CFG_W = 16;

    localparam logic [7:0] HDR_QOS0 = 8'h30;
    localparam logic [7:0] HDR_QOS1 = 8'h32;
    localparam logic [7:0] HDR_QOS2 = 8'h34;

    localparam logic [15:0] TOPIC_LIMIT_RST   = 16'd128;
    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd512;

    localparam logic [1:0]  MAX_LEN_BYTES = 2'd3;
    localparam logic [15:0] PID_BYTES     = 16'd2;
    localparam logic [15:0] TLEN_BYTES    = 16'd2;
    localparam logic [15:0] TLEN_PID_BYTES = 16'd4;

    typedef struct packed {
        kind_t       byte_kind;
        logic [7:0]  data_out;
        logic        packet_end;
        status_t     status;
        logic        has_packet_id;
        logic [15:0] topic_length;
        logic [15:0] payload_length;
    } result_t;

endpackage

// ----- design/mpp_if.sv -----
// ----------------------------------------------------------------------------
// MQTT PUBLISH parser channels
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface mpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface mpp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [7:0]  data_out;
    logic        packet_end;
    logic [2:0]  status;
    logic        has_packet_id;
    logic [15:0] topic_length;
    logic [15:0] payload_length;

    modport source (
        output valid, output byte_kind, output data_out, output packet_end,
        output status, output has_packet_id, output topic_length,
        output payload_length, input ready
    );
    modport sink (
        input valid, input byte_kind, input data_out, input packet_end,
        input status, input has_packet_id, input topic_length,
        input payload_length, output ready
    );
endinterface

// ----- design/mqtt_publish_parser.sv -----
// ----------------------------------------------------------------------------
// MQTT PUBLISH packet parser
// Parses a received PUBLISH packet one byte at a time and gives one result
// item for each byte, with its class, the lengths and the end status.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  rx       in         rx_byte, restart
//  res      out        byte_kind, data_out, packet_end, status,
//                      has_packet_id, topic_length, payload_length
//  cfg      in         cfg_we, cfg_index, cfg_data (topic/payload limits)
//
// One byte is accepted in every cycle while rx ready is high; its result
// item is registered in the output buffer.
// The parse state updates in the same cycle as the byte is accepted.
// A two-entry output buffer keeps rx ready for one more item while the
// sink stalls; rx ready drops only when both entries are full.
// After reset the parser awaits a header byte and the limits are 128 and 512.
// ----------------------------------------------------------------------------
module mqtt_publish_parser (
    input  logic                clk,
    input  logic                rst_n,
    mpp_rx_if.sink              rx,
    mpp_res_if.source           res,
    input  logic                cfg_we,
    input  mpp_pkg::cfg_index_t cfg_index,
    input  logic [15:0]         cfg_data
);
    import mpp_pkg::*;

    result_t item;
    logic    buf_ready;
    logic    take;

    assign rx.ready = buf_ready;
    assign take     = rx.valid && buf_ready;

    mpp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .rx_byte   (rx.rx_byte),
        .restart   (rx.restart),
        .res       (item)
    );

    mpp_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .item  (item),
        .ready (buf_ready),
        .res   (res)
    );

endmodule

// ----- design/mpp_core.sv -----
// ----------------------------------------------------------------------------
// MQTT PUBLISH parser core
// Holds the limit registers and the parse state, and works out the result
// item and the next state for each accepted byte combinationally.
// ----------------------------------------------------------------------------
module mpp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  mpp_pkg::cfg_index_t   cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  take,
    input  logic [7:0]            rx_byte,
    input  logic                  restart,
    output mpp_pkg::result_t      res
);
    import mpp_pkg::*;

    logic [15:0] topic_limit_reg;
    logic [15:0] payload_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [20:0] rem_reg, rem_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] tl_reg, tl_next;
    logic [15:0] bc_reg, bc_next;
    logic        flag_reg, flag_next;
    logic [15:0] pl_reg, pl_next;

    logic        is_header;
    logic        hdr_ok;
    logic [20:0] rem_add;
    logic [15:0] tl_eff;
    logic        tl_too_long;
    logic [15:0] pay_calc;
    logic        pay_too_long;
    logic        pay_zero;
    logic [15:0] bc_inc;
    logic        topic_done;
    logic        pid_done;
    logic        pay_done;
    logic        topic_passed;
    logic        enter_pay;
    phase_t      pay_phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topic_limit_reg   <= TOPIC_LIMIT_RST;
            payload_limit_reg <= PAYLOAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOPIC_LIMIT:   topic_limit_reg   <= cfg_data;
                CFG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data;
                default:           topic_limit_reg   <= topic_limit_reg;
            endcase
        end
    end

    assign is_header = restart || (phase_reg == PH_IDLE);
    assign hdr_ok    = (rx_byte == HDR_QOS0) || (rx_byte == HDR_QOS1) ||
                       (rx_byte == HDR_QOS2);

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    rem_add = {14'd0, rx_byte[6:0]};
            2'd1:    rem_add = {7'd0, rx_byte[6:0], 7'd0};
            2'd2:    rem_add = {rx_byte[6:0], 14'd0};
            default: rem_add = '0;
        endcase
    end

    assign tl_eff       = (phase_reg == PH_TLEN_LO) ? {tl_reg[15:8], rx_byte} : tl_reg;
    assign tl_too_long  = tl_eff >= topic_limit_reg;
    assign pay_calc     = rem_reg[15:0] - tl_eff - (flag_reg ? TLEN_PID_BYTES : TLEN_BYTES);
    assign pay_too_long = pay_calc >= payload_limit_reg;
    assign pay_zero     = pay_calc == 16'd0;
    assign bc_inc       = bc_reg + 16'd1;
    assign topic_done   = bc_inc >= tl_reg;
    assign pid_done     = bc_inc >= PID_BYTES;
    assign pay_done     = bc_inc >= pl_reg;

    assign topic_passed = !is_header &&
        (((phase_reg == PH_TLEN_LO) && !tl_too_long && (tl_eff == 16'd0)) ||
         ((phase_reg == PH_TOPIC) && topic_done));
    assign enter_pay = (topic_passed && !flag_reg) ||
                       (!is_header && (phase_reg == PH_PID) && pid_done);
    assign pay_phase = (pay_too_long || pay_zero) ? PH_IDLE : PH_PAYLOAD;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (is_header)
        begin
            phase_next = hdr_ok ? PH_LEN : PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (cnt_reg >= MAX_LEN_BYTES)
                        phase_next = PH_IDLE;
                    else if (!rx_byte[7])
                        phase_next = PH_TLEN_HI;
                end
                PH_TLEN_HI: phase_next = PH_TLEN_LO;
                PH_TLEN_LO:
                begin
                    if (tl_too_long)
                        phase_next = PH_IDLE;
                    else if (tl_eff != 16'd0)
                        phase_next = PH_TOPIC;
                    else
                        phase_next = flag_reg ? PH_PID : pay_phase;
                end
                PH_TOPIC:
                begin
                    if (topic_done)
                        phase_next = flag_reg ? PH_PID : pay_phase;
                end
                PH_PID:
                begin
                    if (pid_done)
                        phase_next = pay_phase;
                end
                PH_PAYLOAD:
                begin
                    if (pay_done)
                        phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Lengths, counters and the packet id flag.
    always_comb
    begin
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        tl_next   = tl_reg;
        bc_next   = bc_reg;
        flag_next = flag_reg;
        pl_next   = pl_reg;
        if (is_header)
        begin
            rem_next  = '0;
            cnt_next  = '0;
            tl_next   = '0;
            bc_next   = '0;
            pl_next   = '0;
            flag_next = hdr_ok && (rx_byte != HDR_QOS0);
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (cnt_reg < MAX_LEN_BYTES)
                    begin
                        rem_next = rem_reg + rem_add;
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                PH_TLEN_HI: tl_next = {rx_byte, 8'd0};
                PH_TLEN_LO:
                begin
                    tl_next = tl_eff;
                    bc_next = '0;
                end
                PH_TOPIC:   bc_next = topic_done ? 16'd0 : bc_inc;
                PH_PID:     bc_next = pid_done ? 16'd0 : bc_inc;
                PH_PAYLOAD: bc_next = bc_inc;
                default:    bc_next = bc_reg;
            endcase
            if (enter_pay)
                pl_next = pay_calc;
        end
    end

    // Result item.
    always_comb
    begin
        res.byte_kind      = KIND_FRAME;
        res.data_out       = rx_byte;
        res.packet_end     = 1'b0;
        res.status         = ST_OK;
        res.has_packet_id  = flag_next;
        res.topic_length   = tl_next;
        res.payload_length = pl_next;
        if (is_header)
        begin
            if (!hdr_ok)
            begin
                res.packet_end = 1'b1;
                res.status     = ST_BAD_HEADER;
            end
        end
        else
        begin
            if (phase_reg == PH_TOPIC)
                res.byte_kind = KIND_TOPIC;
            else if (phase_reg == PH_PAYLOAD)
                res.byte_kind = KIND_PAYLOAD;

            if ((phase_reg == PH_LEN) && (cnt_reg >= MAX_LEN_BYTES))
            begin
                res.packet_end = 1'b1;
                res.status     = ST_LEN_TOO_LONG;
            end
            else if ((phase_reg == PH_TLEN_LO) && tl_too_long)
            begin
                res.packet_end = 1'b1;
                res.status     = ST_TOPIC_TOO_LONG;
            end
            else if (enter_pay && pay_too_long)
            begin
                res.packet_end = 1'b1;
                res.status     = ST_PAYLOAD_TOO_LONG;
            end
            else if (enter_pay && pay_zero)
            begin
                res.packet_end = 1'b1;
            end
            else if ((phase_reg == PH_PAYLOAD) && pay_done)
            begin
                res.packet_end = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            tl_reg    <= '0;
            bc_reg    <= '0;
            flag_reg  <= 1'b0;
            pl_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            tl_reg    <= tl_next;
            bc_reg    <= bc_next;
            flag_reg  <= flag_next;
            pl_reg    <= pl_next;
        end
    end

    a_status_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && (res.status != ST_OK) |-> res.packet_end)
        else $error("error status without packet end");

    a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && res.packet_end |=> phase_reg == PH_IDLE)
        else $error("parser not idle after packet end");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> pl_reg != 16'd0)
        else $error("payload phase with zero payload length");

endmodule

// ----- design/mpp_out_buf.sv -----
// ----------------------------------------------------------------------------
// MQTT PUBLISH parser output buffer
// Output register with a skid stage, so that a new item is taken while a
// finished result still waits for the sink.
// ----------------------------------------------------------------------------
module mpp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mpp_pkg::result_t  item,
    output logic              ready,
    mpp_res_if.source         res
);
    import mpp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign ready = !skid_valid_reg;
    assign pop   = main_valid_reg && res.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            main_valid_next = skid_valid_reg || push;
            main_next       = skid_valid_reg ? skid_reg : item;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign res.valid          = main_valid_reg;
    assign res.byte_kind      = main_reg.byte_kind;
    assign res.data_out       = main_reg.data_out;
    assign res.packet_end     = main_reg.packet_end;
    assign res.status         = main_reg.status;
    assign res.has_packet_id  = main_reg.has_packet_id;
    assign res.topic_length   = main_reg.topic_length;
    assign res.payload_length = main_reg.payload_length;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage full while output register empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("item pushed into a full buffer");

endmodule

// ----- sim/mqtt_publish_parser_tb.sv -----
// ----------------------------------------------------------------------------
// MQTT PUBLISH parser testbench
// Feeds received bytes to the parser, first from a short table of directed
// cases and then as random packets mixed with truncated packets and noise,
// under several topic and payload limit settings. Every result item is
// checked field by field against a cycle-free model of the parse, or against
// the value given in the table for some directed rows, while both channels
// idle at random and the result side once holds off for a long stretch.
// ----------------------------------------------------------------------------
module mqtt_publish_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 6;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_BODY    = 48;
    localparam int NUM_ROWS    = 26;

    typedef struct packed {
        logic [7:0] b;
        logic       rs;
        logic       known;
        result_t    want;
    } drive_row_t;

    localparam result_t NO_TYPED = '0;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [15:0] cfg_data;

    mpp_rx_if  rx_ch();
    mpp_res_if res_ch();

    mqtt_publish_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Parse state and limits as the block should hold them.
    phase_t      ph;
    logic [20:0] rem_len;
    logic [1:0]  len_cnt;
    logic [15:0] tlen;
    logic [15:0] cnt;
    logic [15:0] plen;
    logic        pid_flag;
    logic [15:0] lim_topic;
    logic [15:0] lim_payload;

    result_t byte_results_q[$];

    int  fail_count      = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  settings_used   = 1;
    int  ends_by_status[8];
    int  hold_request    = 0;
    bit  calm            = 1'b0;
    bit  abort_next      = 1'b0;

    drive_row_t directed_rows [NUM_ROWS] = '{
        '{8'h34, 1'b0, 1'b0, NO_TYPED},
        '{8'h05, 1'b0, 1'b0, NO_TYPED},
        '{8'hFF, 1'b1, 1'b1,
          '{KIND_FRAME, 8'hFF, 1'b1, ST_BAD_HEADER, 1'b0, 16'd0, 16'd0}},
        '{8'h32, 1'b0, 1'b0, NO_TYPED},
        '{8'h07, 1'b0, 1'b0, NO_TYPED},
        '{8'h00, 1'b0, 1'b0, NO_TYPED},
        '{8'h01, 1'b0, 1'b0, NO_TYPED},
        '{8'h61, 1'b0, 1'b0, NO_TYPED},
        '{8'h00, 1'b0, 1'b0, NO_TYPED},
        '{8'h01, 1'b0, 1'b0, NO_TYPED},
        '{8'h55, 1'b0, 1'b0, NO_TYPED},
        '{8'hAA, 1'b0, 1'b0, NO_TYPED},
        '{8'h30, 1'b0, 1'b0, NO_TYPED},
        '{8'hFF, 1'b0, 1'b0, NO_TYPED},
        '{8'hFF, 1'b0, 1'b0, NO_TYPED},
        '{8'hFF, 1'b0, 1'b0, NO_TYPED},
        '{8'h12, 1'b0, 1'b1,
          '{KIND_FRAME, 8'h12, 1'b1, ST_LEN_TOO_LONG, 1'b0, 16'd0, 16'd0}},
        '{8'h30, 1'b1, 1'b0, NO_TYPED},
        '{8'h05, 1'b0, 1'b0, NO_TYPED},
        '{8'h00, 1'b0, 1'b0, NO_TYPED},
        '{8'h80, 1'b0, 1'b1,
          '{KIND_FRAME, 8'h80, 1'b1, ST_TOPIC_TOO_LONG, 1'b0, 16'h0080, 16'd0}},
        '{8'h30, 1'b0, 1'b0, NO_TYPED},
        '{8'hFF, 1'b0, 1'b0, NO_TYPED},
        '{8'h07, 1'b0, 1'b0, NO_TYPED},
        '{8'h00, 1'b0, 1'b0, NO_TYPED},
        '{8'h00, 1'b0, 1'b1,
          '{KIND_FRAME, 8'h00, 1'b1, ST_PAYLOAD_TOO_LONG, 1'b0, 16'd0, 16'd1021}}
    };

    function automatic void open_payload(inout logic fin, inout status_t st);
        logic [15:0] framing;
        framing = pid_flag ? TLEN_PID_BYTES : TLEN_BYTES;
        plen = 16'(rem_len - 21'(tlen) - 21'(framing));
        cnt = '0;
        if (plen >= lim_payload)
        begin
            fin = 1'b1;
            st  = ST_PAYLOAD_TOO_LONG;
            ph  = PH_IDLE;
        end
        else if (plen == 16'd0)
        begin
            fin = 1'b1;
            st  = ST_OK;
            ph  = PH_IDLE;
        end
        else
        begin
            ph = PH_PAYLOAD;
        end
    endfunction

    function automatic void close_topic(inout logic fin, inout status_t st);
        cnt = '0;
        if (pid_flag)
            ph = PH_PID;
        else
            open_payload(fin, st);
    endfunction

    function automatic result_t parse_rx_byte(input logic [7:0] b, input logic rs);
        kind_t   k;
        logic    fin;
        status_t st;
        result_t r;
        k   = KIND_FRAME;
        fin = 1'b0;
        st  = ST_OK;
        if (rs || ph == PH_IDLE)
        begin
            rem_len  = '0;
            len_cnt  = '0;
            tlen     = '0;
            cnt      = '0;
            plen     = '0;
            pid_flag = 1'b0;
            if (b == HDR_QOS0 || b == HDR_QOS1 || b == HDR_QOS2)
            begin
                pid_flag = (b != HDR_QOS0);
                ph = PH_LEN;
            end
            else
            begin
                fin = 1'b1;
                st  = ST_BAD_HEADER;
                ph  = PH_IDLE;
            end
        end
        else
        begin
            case (ph)
                PH_LEN:
                begin
                    if (len_cnt >= MAX_LEN_BYTES)
                    begin
                        fin = 1'b1;
                        st  = ST_LEN_TOO_LONG;
                        ph  = PH_IDLE;
                    end
                    else
                    begin
                        rem_len = rem_len + (21'(b[6:0]) << (7 * len_cnt));
                        len_cnt = len_cnt + 2'd1;
                        if (!b[7])
                            ph = PH_TLEN_HI;
                    end
                end
                PH_TLEN_HI:
                begin
                    tlen = {b, 8'h00};
                    ph = PH_TLEN_LO;
                end
                PH_TLEN_LO:
                begin
                    tlen = {tlen[15:8], b};
                    cnt = '0;
                    if (tlen >= lim_topic)
                    begin
                        fin = 1'b1;
                        st  = ST_TOPIC_TOO_LONG;
                        ph  = PH_IDLE;
                    end
                    else if (tlen == 16'd0)
                        close_topic(fin, st);
                    else
                        ph = PH_TOPIC;
                end
                PH_TOPIC:
                begin
                    k = KIND_TOPIC;
                    cnt = cnt + 16'd1;
                    if (cnt >= tlen)
                        close_topic(fin, st);
                end
                PH_PID:
                begin
                    cnt = cnt + 16'd1;
                    if (cnt >= PID_BYTES)
                        open_payload(fin, st);
                end
                default:
                begin
                    k = KIND_PAYLOAD;
                    cnt = cnt + 16'd1;
                    if (cnt >= plen)
                    begin
                        fin = 1'b1;
                        st  = ST_OK;
                        ph  = PH_IDLE;
                    end
                end
            endcase
        end
        r.byte_kind      = k;
        r.data_out       = b;
        r.packet_end     = fin;
        r.status         = st;
        r.has_packet_id  = pid_flag;
        r.topic_length   = tlen;
        r.payload_length = plen;
        return r;
    endfunction

    task automatic offer_byte(input logic [7:0] b, input logic rs, input logic known,
                              input result_t typed);
        int      gap;
        result_t predicted;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.restart <= rs;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        predicted = parse_rx_byte(b, rs);
        byte_results_q.push_back(known ? typed : predicted);
        items_sent++;
    endtask

    function automatic int pick_len(input logic [15:0] lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, (lim > 16'd7) ? 6 : int'(lim) - 1);
        if (r < 85)
            return int'(lim) - $urandom_range(0, 1);
        return $urandom_range(0, 65535);
    endfunction

    task automatic send_packet();
        logic [7:0]  pkt[$];
        logic [7:0]  lb [4];
        logic [7:0]  hdr;
        logic [20:0] rem;
        logic [20:0] left;
        logic [15:0] tlv;
        int          tl;
        int          pl;
        int          sel;
        int          n;
        int          cut;
        sel = $urandom_range(0, 2);
        hdr = (sel == 0) ? HDR_QOS0 : (sel == 1) ? HDR_QOS1 : HDR_QOS2;
        tl  = pick_len(lim_topic);
        pl  = pick_len(lim_payload);
        tlv = 16'(tl);
        rem = 21'(2 + tl + ((hdr != HDR_QOS0) ? 2 : 0) + pl);
        if ($urandom_range(0, 7) == 0)
            rem = 21'($urandom);
        pkt.push_back(hdr);
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            repeat (3) pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
            pkt.push_back(8'($urandom));
        end
        else
        begin
            n = 0;
            left = rem;
            do
            begin
                lb[n] = {1'b0, left[6:0]};
                left = left >> 7;
                if (left != 0)
                    lb[n][7] = 1'b1;
                n++;
            end
            while (left != 0);
            if (sel == 1 && n < 3)
            begin
                lb[n - 1][7] = 1'b1;
                lb[n] = 8'h00;
                n++;
            end
            for (int i = 0; i < n; i++)
                pkt.push_back(lb[i]);
        end
        pkt.push_back(tlv[15:8]);
        pkt.push_back(tlv[7:0]);
        for (int i = 0; i < tl && i < MAX_BODY; i++)
            pkt.push_back(8'($urandom));
        if (hdr != HDR_QOS0)
            repeat (2) pkt.push_back(8'($urandom));
        for (int i = 0; i < pl && i < MAX_BODY; i++)
            pkt.push_back(8'($urandom));
        cut = pkt.size();
        if (tl > MAX_BODY || pl > MAX_BODY || $urandom_range(0, 19) == 0)
            cut = $urandom_range(1, pkt.size());
        for (int i = 0; i < cut; i++)
            offer_byte(pkt[i], (i == 0) && (abort_next || $urandom_range(0, 9) == 0),
                       1'b0, NO_TYPED);
        abort_next = (cut < pkt.size());
    endtask

    task automatic write_limits(input logic [15:0] t, input logic [15:0] p);
        rx_ch.valid <= 1'b0;
        while (byte_results_q.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOPIC_LIMIT;
        cfg_data  <= t;
        @(posedge clk);
        lim_topic = t;
        cfg_index <= CFG_PAYLOAD_LIMIT;
        cfg_data  <= p;
        @(posedge clk);
        lim_payload = p;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int phase_start;
        ph          = PH_IDLE;
        rem_len     = '0;
        len_cnt     = '0;
        tlen        = '0;
        cnt         = '0;
        plen        = '0;
        pid_flag    = 1'b0;
        lim_topic   = TOPIC_LIMIT_RST;
        lim_payload = PAYLOAD_LIMIT_RST;
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        rx_ch.restart <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_TOPIC_LIMIT;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            offer_byte(directed_rows[i].b, directed_rows[i].rs, directed_rows[i].known,
                       directed_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                1: write_limits(16'd1, 16'd1);
                2: write_limits(16'hFFFF, 16'hFFFF);
                3: write_limits(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
                4: write_limits(16'd8, 16'hFFFF);
                5: write_limits(16'hFFFF, 16'd3);
                default: ;
            endcase
            calm = (p == 4);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (p == 2 && items_sent - phase_start > 20 && hold_request == 0)
                    hold_request = HOLD_CYCLES;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4))
                        offer_byte(8'($urandom), $urandom_range(0, 9) == 0, 1'b0, NO_TYPED);
                else
                    send_packet();
            end
        end

        rx_ch.valid <= 1'b0;
        while (byte_results_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (byte_results_q.size() != 0)
            fail_count++;
        $display("tb: %0d bytes sent and %0d result items checked under %0d limit settings",
                 items_sent, results_checked, settings_used);
        $display("tb: packet ends ok %0d, header %0d, length %0d, topic %0d, payload %0d",
                 ends_by_status[ST_OK], ends_by_status[ST_BAD_HEADER],
                 ends_by_status[ST_LEN_TOO_LONG], ends_by_status[ST_TOPIC_TOO_LONG],
                 ends_by_status[ST_PAYLOAD_TOO_LONG]);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : result_sink
        int      stall;
        result_t got;
        result_t want;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = -1;
            end
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            got.byte_kind      = kind_t'(res_ch.byte_kind);
            got.data_out       = res_ch.data_out;
            got.packet_end     = res_ch.packet_end;
            got.status         = status_t'(res_ch.status);
            got.has_packet_id  = res_ch.has_packet_id;
            got.topic_length   = res_ch.topic_length;
            got.payload_length = res_ch.payload_length;
            if (byte_results_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("tb: result item with nothing expected, data %h", got.data_out);
            end
            else
            begin
                want = byte_results_q.pop_front();
                if (got.byte_kind !== want.byte_kind || got.data_out !== want.data_out ||
                    got.packet_end !== want.packet_end || got.status !== want.status ||
                    got.has_packet_id !== want.has_packet_id ||
                    got.topic_length !== want.topic_length ||
                    got.payload_length !== want.payload_length)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("tb: mismatch on result item %0d", results_checked);
                        $display("    expected kind %0d data %h end %b status %0d id %b tlen %0d plen %0d",
                                 want.byte_kind, want.data_out, want.packet_end, want.status,
                                 want.has_packet_id, want.topic_length, want.payload_length);
                        $display("    actual   kind %0d data %h end %b status %0d id %b tlen %0d plen %0d",
                                 got.byte_kind, got.data_out, got.packet_end, got.status,
                                 got.has_packet_id, got.topic_length, got.payload_length);
                    end
                end
            end
            if (got.packet_end === 1'b1)
                ends_by_status[got.status]++;
            results_checked++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: no item moved for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- mqtt_publish_parser.f -----
design/mpp_pkg.sv
design/mpp_if.sv
design/mpp_core.sv
design/mpp_out_buf.sv
design/mqtt_publish_parser.sv
sim/mqtt_publish_parser_tb.sv
